// ===== hdl/qked_pkg.sv =====
// Package for the quadrature knob event decoder: types, codes, reset values and tables.
`default_nettype none

package qked_pkg;

    // Field widths of one beat.
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned GAP_W   = 16;
    localparam int unsigned STEP_W  = 4;
    localparam int unsigned EVENT_W = 3;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Event codes carried in the result beat.
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE  = 3'd0,
        EV_CW    = 3'd1,
        EV_CCW   = 3'd2,
        EV_CLICK = 3'd3,
        EV_LONG  = 3'd4
    } t_event;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAST_GAP   = 3'd0,
        CFG_SLOW_GAP   = 3'd1,
        CFG_MAX_STEP   = 3'd2,
        CFG_LONG_PRESS = 3'd3,
        CFG_CLICK_MIN  = 3'd4
    } t_cfg_idx;

    // Configuration register set.
    typedef struct packed {
        logic [GAP_W-1:0]  fast_gap_ms;
        logic [GAP_W-1:0]  slow_gap_ms;
        logic [STEP_W-1:0] max_step;
        logic [GAP_W-1:0]  long_press_ms;
        logic [GAP_W-1:0]  click_min_ms;
    } t_cfg;

    localparam logic [GAP_W-1:0]  RST_FAST_GAP   = 16'd100;
    localparam logic [GAP_W-1:0]  RST_SLOW_GAP   = 16'd300;
    localparam logic [STEP_W-1:0] RST_MAX_STEP   = 4'd10;
    localparam logic [GAP_W-1:0]  RST_LONG_PRESS = 16'd1000;
    localparam logic [GAP_W-1:0]  RST_CLICK_MIN  = 16'd50;

    // Quadrature transition table, indexed by {previous AB, current AB},
    // entries in two's complement: +1, 0 or -1.
    localparam logic [1:0] QUAD_TABLE [16] = '{
        2'b00, 2'b11, 2'b01, 2'b00,
        2'b01, 2'b00, 2'b00, 2'b11,
        2'b11, 2'b00, 2'b00, 2'b01,
        2'b00, 2'b01, 2'b11, 2'b00
    };

endpackage

`default_nettype wire

// ===== hdl/qked_in_if.sv =====
// Input channel of the knob decoder: one poll of the knob per beat.
`default_nettype none

interface qked_in_if
    import qked_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              phase_a;
    logic              phase_b;
    logic              button_level;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, phase_a, phase_b, button_level, now_ms, input ready);
    modport sink   (input valid, phase_a, phase_b, button_level, now_ms, output ready);
endinterface

`default_nettype wire

// ===== hdl/qked_out_if.sv =====
// Output channel of the knob decoder: one event result per beat.
`default_nettype none

interface qked_out_if
    import qked_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_code;
    logic [STEP_W-1:0]  step_size;
    logic [TIME_W-1:0]  last_activity_ms;

    modport source (output valid, event_code, step_size, last_activity_ms, input ready);
    modport sink   (input valid, event_code, step_size, last_activity_ms, output ready);
endinterface

`default_nettype wire

// ===== hdl/quadrature_knob_event_decoder_core.sv =====
// Each accepted poll beat's result beat is registered in the output register.
// Throughput: one poll per cycle; the whole update is one pass of logic into the state
// and output registers, and a new poll is taken whenever the output register is empty
// or being read in the same cycle.
// Reset (synchronous, active low): all knob and button state cleared, step size one,
// configuration registers return to their default values, no result pending.
`default_nettype none

module quadrature_knob_event_decoder_core
    import qked_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    qked_in_if.sink                    i_in,
    qked_out_if.source                 o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam logic signed [CNT_W-1:0] CNT_CW  = 3'sd2;
    localparam logic signed [CNT_W-1:0] CNT_CCW = -3'sd2;

    // Configuration and knob state.
    t_cfg                     r_cfg;
    logic [1:0]               r_prev_phase, n_prev_phase;
    logic signed [CNT_W-1:0]  r_phase_count, n_phase_count;
    logic [STEP_W-1:0]        r_accel_step, n_accel_step;
    logic [TIME_W-1:0]        r_last_turn, n_last_turn;
    logic [TIME_W-1:0]        r_activity, n_activity;
    logic                     r_pressed, n_pressed;
    logic [TIME_W-1:0]        r_press_start, n_press_start;
    logic                     r_long_pending, n_long_pending;

    // Output register.
    logic                     r_out_valid;
    t_event                   r_event, n_event;
    logic [STEP_W-1:0]        r_step_out;
    logic [TIME_W-1:0]        r_activity_out;

    logic                     accept;
    logic [1:0]               ab;
    logic [1:0]               quad;
    logic signed [CNT_W-1:0]  cnt_sum;
    logic                     turn;
    logic [TIME_W-1:0]        gap;
    logic [STEP_W-1:0]        accel_next;
    logic [TIME_W-1:0]        held;

    assign accept     = i_in.valid && i_in.ready;
    assign i_in.ready = !r_out_valid || o_out.ready;

    // Quadrature decode of the new phase against the previous one.
    assign ab      = {i_in.phase_a, i_in.phase_b};
    assign quad    = QUAD_TABLE[{r_prev_phase, ab}];
    assign cnt_sum = r_phase_count + $signed({quad[1], quad});
    assign turn    = (cnt_sum >= CNT_CW) || (cnt_sum <= CNT_CCW);
    assign gap     = i_in.now_ms - r_last_turn;

    qked_accel u_accel (
        .i_gap  (gap),
        .i_step (r_accel_step),
        .i_cfg  (r_cfg),
        .o_step (accel_next)
    );

    // Rotation first; on a poll without rotation, the button decode.
    always_comb begin
        n_prev_phase   = ab;
        n_phase_count  = cnt_sum;
        n_accel_step   = r_accel_step;
        n_last_turn    = r_last_turn;
        n_activity     = r_activity;
        n_pressed      = r_pressed;
        n_press_start  = r_press_start;
        n_long_pending = r_long_pending;
        n_event        = EV_NONE;
        held           = i_in.now_ms - r_press_start;

        if (turn) begin
            n_phase_count = '0;
            n_accel_step  = accel_next;
            n_last_turn   = i_in.now_ms;
            n_activity    = i_in.now_ms;
            n_event       = (cnt_sum >= CNT_CW) ? EV_CW : EV_CCW;
        end else begin
            // A new press starts timing.
            if (!r_pressed && !i_in.button_level) begin
                n_pressed     = 1'b1;
                n_press_start = i_in.now_ms;
                n_activity    = i_in.now_ms;
                held          = '0;
            end
            if (r_long_pending) begin
                n_long_pending = 1'b0;
                n_event        = EV_LONG;
            end else if (n_pressed && i_in.button_level) begin
                // Release: classify by hold time.
                n_pressed = 1'b0;
                if (held > {{(TIME_W-GAP_W){1'b0}}, r_cfg.long_press_ms}) begin
                    n_event = EV_LONG;
                end else if (held > {{(TIME_W-GAP_W){1'b0}}, r_cfg.click_min_ms}) begin
                    n_event = EV_CLICK;
                end
            end else if (n_pressed &&
                         held > {{(TIME_W-GAP_W){1'b0}}, r_cfg.long_press_ms}) begin
                // Still held past the long-press time: arm the next poll.
                n_long_pending = 1'b1;
            end
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fast_gap_ms   <= RST_FAST_GAP;
            r_cfg.slow_gap_ms   <= RST_SLOW_GAP;
            r_cfg.max_step      <= RST_MAX_STEP;
            r_cfg.long_press_ms <= RST_LONG_PRESS;
            r_cfg.click_min_ms  <= RST_CLICK_MIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FAST_GAP:   r_cfg.fast_gap_ms   <= i_cfg_wdata;
                CFG_SLOW_GAP:   r_cfg.slow_gap_ms   <= i_cfg_wdata;
                CFG_MAX_STEP:   r_cfg.max_step      <= i_cfg_wdata[STEP_W-1:0];
                CFG_LONG_PRESS: r_cfg.long_press_ms <= i_cfg_wdata;
                CFG_CLICK_MIN:  r_cfg.click_min_ms  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Knob and button state, updated once per accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_phase   <= '0;
            r_phase_count  <= '0;
            r_accel_step   <= STEP_W'(1);
            r_last_turn    <= '0;
            r_activity     <= '0;
            r_pressed      <= 1'b0;
            r_press_start  <= '0;
            r_long_pending <= 1'b0;
        end else if (accept) begin
            r_prev_phase   <= n_prev_phase;
            r_phase_count  <= n_phase_count;
            r_accel_step   <= n_accel_step;
            r_last_turn    <= n_last_turn;
            r_activity     <= n_activity;
            r_pressed      <= n_pressed;
            r_press_start  <= n_press_start;
            r_long_pending <= n_long_pending;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_event        <= n_event;
            r_step_out     <= n_accel_step;
            r_activity_out <= n_activity;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.event_code       = r_event;
    assign o_out.step_size        = r_step_out;
    assign o_out.last_activity_ms = r_activity_out;

endmodule

`default_nettype wire

// ===== hdl/qked_accel.sv =====
// Rotation acceleration: next step size from the gap since the previous rotation event.
`default_nettype none

module qked_accel
    import qked_pkg::*;
(
    input  wire logic [TIME_W-1:0] i_gap,
    input  wire logic [STEP_W-1:0] i_step,
    input  wire t_cfg              i_cfg,
    output logic      [STEP_W-1:0] o_step
);

    logic [STEP_W-1:0] lim;
    logic [STEP_W-1:0] s;

    // A zero limit behaves as a limit of one.
    assign lim = (i_cfg.max_step == '0) ? STEP_W'(1) : i_cfg.max_step;

    // Grow on fast turns, fall back to one on slow turns, then clamp.
    always_comb begin
        if (i_gap < {{(TIME_W-GAP_W){1'b0}}, i_cfg.fast_gap_ms}) begin
            s = (i_step < lim) ? i_step + STEP_W'(1) : i_step;
        end else if (i_gap > {{(TIME_W-GAP_W){1'b0}}, i_cfg.slow_gap_ms}) begin
            s = STEP_W'(1);
        end else begin
            s = i_step;
        end
        if (s == '0) begin
            s = STEP_W'(1);
        end
        if (s > lim) begin
            s = lim;
        end
        o_step = s;
    end

endmodule

`default_nettype wire
